>>> rtl/core/indexed_max_priority_table_assert.svh
// ---------------------------------------------------------------------------
// indexed_max_priority_table_assert.svh
// Assertion macros for the indexed max-priority table. The clock is clk and
// the asynchronous active-low reset is arst_n.
// ---------------------------------------------------------------------------
`ifndef INDEXED_MAX_PRIORITY_TABLE_ASSERT_SVH
`define INDEXED_MAX_PRIORITY_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMPT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/impt_pkg.sv
// ---------------------------------------------------------------------------
// impt_pkg
// Field widths, function and status codes, and the result record of the
// indexed max-priority table.
// ---------------------------------------------------------------------------
package impt_pkg;

	localparam int FUNC_W    = 3;
	localparam int ID_W      = 8;
	localparam int DIN_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int RDATA_W   = 32;
	localparam int RPRIO_W   = 16;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 64;
	localparam int M_PAD_W   = M_TDATA_W - (ID_W + RDATA_W + RPRIO_W + 1);

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD     = 3'd0,
		FN_PROMOTE = 3'd1,
		FN_GET_MAX = 3'd2,
		FN_POP_MAX = 3'd3,
		FN_QUERY   = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BAD_ID = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		status_t              status;
		logic [ID_W-1:0]      id;
		logic [RDATA_W-1:0]   data;
		logic [RPRIO_W-1:0]   prio;
		logic                 live;
	} result_t;

endpackage

>>> rtl/core/impt_entry_ram.sv
// ---------------------------------------------------------------------------
// impt_entry_ram
// Entry store: one write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module impt_entry_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/indexed_max_priority_table.sv
// ---------------------------------------------------------------------------
// indexed_max_priority_table
// Table of data words with priorities: add, promote, get/pop max, query.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+---------
//  s_*     | in  | entry_id[7:0], data_in[39:8]                | func
//  m_*     | out | result_id[7:0], result_data[39:8],          | status
//          |     | result_priority[55:40], is_live[56], 0 pad  |
//
//  Add, promote, query and unknown codes: accept, then finish in S_SIMPLE or S_LOOKUP.
//  Get_max and pop_max sweep the entry store through its single read port,
//  one entry per cycle, then report the result in S_MAX_OUT.
//  One transaction is in work at a time; a finished result waits in the output
//  register, and the next input is taken while it waits.
//  Reset clears the add count and control state, not the store; entries at or
//  above the count read as not live: no clearing pass, block ready after reset.
//  A stall on m_tready holds the finishing state until the output is free.
// ---------------------------------------------------------------------------
module indexed_max_priority_table
	import impt_pkg::*;
#(
	parameter int ENTRIES        = 256,
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // entry_id, data_in
	input  logic [FUNC_W-1:0]    s_tuser,   // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // result_id, result_data, result_priority,
	                                        // is_live, zero pad
	output logic [STATUS_W-1:0]  m_tuser    // status
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int WORD_W = DATA_WIDTH + PRIORITY_WIDTH + 1;
	localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;
	localparam int RID_W  = (IDX_W > ID_W) ? IDX_W : ID_W;

	// Stored word: {live, priority, data}
	typedef enum logic [2:0] {
		S_IDLE,
		S_SIMPLE,   // add or unknown code
		S_LOOKUP,   // promote or query, entry word in hand
		S_SCAN,     // max sweep, one entry per cycle
		S_MAX_OUT   // report max, clear live on pop
	} state_t;

	state_t                    state_q;
	func_t                     func_q;
	logic [ID_W-1:0]           id_q;
	logic [DATA_WIDTH-1:0]     din_q;
	logic [CNT_W-1:0]          count_q;       // ids handed out so far
	logic [IDX_W-1:0]          chk_addr_q;    // address of the word in rd_word
	logic                      found_q;
	logic [IDX_W-1:0]          best_id_q;
	logic [PRIORITY_WIDTH-1:0] best_prio_q;
	logic [DATA_WIDTH-1:0]     best_data_q;
	logic                      out_valid_q;
	result_t                   out_q;

	logic                      in_accept;
	logic                      out_free;
	logic                      out_load;
	result_t                   out_next;
	logic                      mem_re;
	logic [IDX_W-1:0]          mem_raddr;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_waddr;
	logic [WORD_W-1:0]         mem_wdata;
	logic [WORD_W-1:0]         rd_word;
	logic [DATA_WIDTH-1:0]     rd_data_f;
	logic [PRIORITY_WIDTH-1:0] rd_prio_f;
	logic                      rd_live_f;
	logic                      table_full;
	logic                      lookup_ok;
	logic                      scan_hit;
	logic                      scan_last;
	logic [PRIORITY_WIDTH-1:0] prio_inc;
	logic [RID_W-1:0]          count_id_ext;
	logic [RID_W-1:0]          best_id_ext;

	impt_entry_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_word)
	);

	assign rd_data_f = rd_word[DATA_WIDTH-1:0];
	assign rd_prio_f = rd_word[DATA_WIDTH +: PRIORITY_WIDTH];
	assign rd_live_f = rd_word[WORD_W-1];

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign table_full = (count_q == CNT_W'(ENTRIES));
	// An id at or past the add count was never written, whatever the store holds.
	assign lookup_ok  = rd_live_f && (CMP_W'(id_q) < CMP_W'(count_q));
	assign scan_hit   = rd_live_f && (CNT_W'(chk_addr_q) < count_q) &&
	                    (!found_q || rd_prio_f >= best_prio_q);
	assign scan_last  = (chk_addr_q == IDX_W'(ENTRIES - 1));
	assign prio_inc   = (rd_prio_f == '1) ? rd_prio_f : rd_prio_f + PRIORITY_WIDTH'(1);

	assign count_id_ext = RID_W'(count_q);
	assign best_id_ext  = RID_W'(best_id_q);

	// Memory port control and result formation. Writes land only in finishing
	// states, which always return to idle, so a read never meets a write to
	// the same entry in one cycle.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = chk_addr_q + IDX_W'(1);
		mem_we    = 1'b0;
		mem_waddr = IDX_W'(count_q);
		mem_wdata = {1'b1, {PRIORITY_WIDTH{1'b0}}, din_q};
		out_load  = 1'b0;
		out_next  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					case (func_t'(s_tuser))
						FN_PROMOTE, FN_QUERY: begin
							mem_re    = 1'b1;
							mem_raddr = IDX_W'(s_tdata[ID_W-1:0]);
						end
						FN_GET_MAX, FN_POP_MAX: begin
							mem_re    = 1'b1;
							mem_raddr = '0;
						end
						default: ;
					endcase
				end
			end
			S_SIMPLE: begin
				if (out_free) begin
					out_load = 1'b1;
					if (func_q == FN_ADD) begin
						if (table_full) begin
							out_next.status = ST_FULL;
						end else begin
							mem_we          = 1'b1;
							out_next.status = ST_OK;
							out_next.id     = count_id_ext[ID_W-1:0];
						end
					end
				end
			end
			S_LOOKUP: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!lookup_ok) begin
						out_next.status = ST_BAD_ID;
					end else if (func_q == FN_PROMOTE) begin
						mem_we          = 1'b1;
						mem_waddr       = IDX_W'(id_q);
						mem_wdata       = {1'b1, prio_inc, rd_data_f};
						out_next.status = ST_OK;
						out_next.prio   = RPRIO_W'(prio_inc);
					end else begin
						out_next.status = ST_OK;
						out_next.data   = RDATA_W'(rd_data_f);
						out_next.prio   = RPRIO_W'(rd_prio_f);
						out_next.live   = 1'b1;
					end
				end
			end
			S_SCAN: begin
				mem_re = !scan_last;
			end
			S_MAX_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!found_q) begin
						out_next.status = ST_EMPTY;
					end else begin
						out_next.status = ST_OK;
						out_next.id     = best_id_ext[ID_W-1:0];
						out_next.data   = RDATA_W'(best_data_q);
						out_next.prio   = RPRIO_W'(best_prio_q);
						if (func_q == FN_POP_MAX) begin
							mem_we    = 1'b1;
							mem_waddr = best_id_q;
							mem_wdata = {1'b0, best_prio_q, best_data_q};
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			chk_addr_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (func_t'(s_tuser))
							FN_PROMOTE, FN_QUERY: state_q <= S_LOOKUP;
							FN_GET_MAX, FN_POP_MAX: begin
								state_q    <= S_SCAN;
								chk_addr_q <= '0;
								found_q    <= 1'b0;
							end
							default: state_q <= S_SIMPLE;
						endcase
					end
				end
				S_SIMPLE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (func_q == FN_ADD && !table_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				S_LOOKUP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= S_MAX_OUT;
					end else begin
						chk_addr_q <= chk_addr_q + IDX_W'(1);
					end
				end
				S_MAX_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload: command fields, running best entry, output register.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func_t'(s_tuser);
			id_q   <= s_tdata[ID_W-1:0];
			din_q  <= DATA_WIDTH'(s_tdata[ID_W +: DIN_W]);
		end
		if (state_q == S_SCAN && scan_hit) begin
			best_id_q   <= chk_addr_q;
			best_prio_q <= rd_prio_f;
			best_data_q <= rd_data_f;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_q.live, out_q.prio, out_q.data, out_q.id};

`include "indexed_max_priority_table_assert.svh"

	`IMPT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(ENTRIES), "add count past table size")
	`IMPT_ASSERT_NEXT(a_one_in_work, in_accept, !s_tready, "input taken while a transaction is in work")
	`IMPT_ASSERT_IMPL(a_no_write_in_scan, state_q == S_SCAN, !mem_we, "store written during max sweep")
	`IMPT_ASSERT_NEXT(a_count_step, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)), "add count moved by more than one")
	`IMPT_ASSERT_IMPL(a_pop_clears_live, mem_we && state_q == S_MAX_OUT, !mem_wdata[WORD_W-1], "pop left entry live")

endmodule
